// File: hdl/lsga_pkg.sv
// ----------------------------------------------------------------------------
// lsga_pkg
// Shared types and constants of the least-served grant arbiter.
// ----------------------------------------------------------------------------
package lsga_pkg;

    localparam int MAX_SLAVES = 8;
    localparam int IDX_W      = $clog2(MAX_SLAVES);
    localparam int ADDR_W     = 4;
    localparam int SIZE_W     = 12;
    localparam int TOTAL_W    = 32;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int ACTION_W   = 3;
    localparam int REQ_W      = SIZE_W + ADDR_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NEW_CYCLE = 3'd0,
        ACT_RTS       = 3'd1,
        ACT_GRANT     = 3'd2,
        ACT_DATA      = 3'd3,
        ACT_RESTART   = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_COUNT = 1'd0,
        CFG_OWN_ADDRESS = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] packet_dst;
        logic [ADDR_W-1:0] packet_src;
    } t_in_item;

    typedef struct packed {
        logic              bad_slave;
        logic [7:0]        ack_mask;
        logic [SIZE_W-1:0] grant_size;
        logic [ADDR_W-1:0] grant_slave;
        logic              granted;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// File: hdl/lsga_ram.sv
// ----------------------------------------------------------------------------
// lsga_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lsga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mac_least_served_grant_arbiter_unit.sv
// ----------------------------------------------------------------------------
// mac_least_served_grant_arbiter_unit
// Master-side grant scheduler: per-slave request table, least-served grant.
// ----------------------------------------------------------------------------
// Every item yields exactly one result item. New cycle, RTS, data received,
// restart and unused actions are answered straight from the idle state. A
// grant scans the granted totals, kept in a single-port RAM, one slave per
// cycle over all 8 entries, followed by one read of the request RAM and one
// write-back of the winner's total. Request flags and per-entry total valid
// bits are flip-flops, so reset, restart and a slave_count write clear the
// table at once with no clearing pass. The result register lets a new item
// in while a result is still waiting, as long as it is taken the same cycle.
module mac_least_served_grant_arbiter_unit
    import lsga_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // packet_src[3:0], packet_dst[7:4], request_size[19:8], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // granted[0], grant_slave[4:1], grant_size[16:5], ack_mask[24:17],
    // bad_slave[25], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_best, n_best;
    logic [TOTAL_W-1:0]   r_best_tot, n_best_tot;
    logic [MAX_SLAVES-1:0] r_flag, n_flag;
    logic [MAX_SLAVES-1:0] r_tot_vld, n_tot_vld;
    logic [7:0]           r_ack, n_ack;
    logic [ADDR_W-1:0]    r_lw, n_lw;
    logic                 r_lw_dz, n_lw_dz;
    logic [CNT_W-1:0]     r_slave_cnt, n_slave_cnt;
    logic [ADDR_W-1:0]    r_own, n_own;
    logic                 r_out_vld, n_out_vld;
    t_result              r_out, n_out;

    t_in_item             w_in;
    t_action              w_act;
    logic [CNT_W-1:0]     w_n;
    logic                 w_out_free;
    logic                 w_accept;
    logic [TOTAL_W-1:0]   w_tot_rd;
    logic [TOTAL_W-1:0]   w_tot_rdata;
    logic                 w_tot_we;
    logic [IDX_W-1:0]     w_tot_addr;
    logic [TOTAL_W-1:0]   w_tot_wdata;
    logic                 w_req_we;
    logic [IDX_W-1:0]     w_req_addr;
    logic [REQ_W-1:0]     w_req_wdata;
    logic [REQ_W-1:0]     w_req_rdata;
    logic [SIZE_W-1:0]    w_req_bytes;
    logic [ADDR_W-1:0]    w_req_dest;
    logic [IDX_W-1:0]     w_src_idx;

    assign w_in        = t_in_item'(s_axis_tdata[REQ_W+ADDR_W-1:0]);
    assign w_act       = t_action'(s_axis_tuser);
    assign w_n         = (r_slave_cnt > CNT_W'(MAX_SLAVES)) ? CNT_W'(MAX_SLAVES) : r_slave_cnt;
    assign w_out_free  = !r_out_vld || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_tot_rd    = r_tot_vld[r_rd_idx] ? w_tot_rdata : '0;
    assign w_req_bytes = w_req_rdata[REQ_W-1:ADDR_W];
    assign w_req_dest  = w_req_rdata[ADDR_W-1:0];
    assign w_src_idx   = IDX_W'(w_in.packet_src - ADDR_W'(1));

    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, r_out};

    lsga_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_SLAVES)) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (w_tot_we),
        .i_addr  (w_tot_addr),
        .i_wdata (w_tot_wdata),
        .o_rdata (w_tot_rdata)
    );

    lsga_ram #(.WIDTH(REQ_W), .DEPTH(MAX_SLAVES)) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (w_req_we),
        .i_addr  (w_req_addr),
        .i_wdata (w_req_wdata),
        .o_rdata (w_req_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_flag      <= '0;
            r_tot_vld   <= '0;
            r_ack       <= '0;
            r_lw        <= '0;
            r_lw_dz     <= 1'b0;
            r_slave_cnt <= CNT_W'(MAX_SLAVES);
            r_own       <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_flag      <= n_flag;
            r_tot_vld   <= n_tot_vld;
            r_ack       <= n_ack;
            r_lw        <= n_lw;
            r_lw_dz     <= n_lw_dz;
            r_slave_cnt <= n_slave_cnt;
            r_own       <= n_own;
            r_out_vld   <= n_out_vld;
        end
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_tot <= n_best_tot;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_tot  = r_best_tot;
        n_flag      = r_flag;
        n_tot_vld   = r_tot_vld;
        n_ack       = r_ack;
        n_lw        = r_lw;
        n_lw_dz     = r_lw_dz;
        n_slave_cnt = r_slave_cnt;
        n_own       = r_own;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out       = r_out;
        w_tot_we    = 1'b0;
        w_tot_addr  = r_idx;
        w_tot_wdata = r_best_tot + TOTAL_W'(w_req_bytes);
        w_req_we    = 1'b0;
        w_req_addr  = r_best;
        w_req_wdata = {w_in.request_size, w_in.packet_dst};

        // fold in the total read last cycle
        if (r_rd_vld && r_flag[r_rd_idx] && ({1'b0, r_rd_idx} < w_n) &&
            (!r_found || (w_tot_rd < r_best_tot))) begin
            n_found    = 1'b1;
            n_best     = r_rd_idx;
            n_best_tot = w_tot_rd;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    case (w_act)
                        ACT_NEW_CYCLE, ACT_RESTART: begin
                            n_out.ack_mask = r_ack;
                            n_ack   = '0;
                            n_lw    = '0;
                            n_lw_dz = 1'b0;
                            n_flag  = '0;
                            if (w_act == ACT_RESTART) begin
                                n_tot_vld = '0;
                            end
                        end
                        ACT_RTS: begin
                            if (w_in.request_size != '0) begin
                                if (w_in.packet_src != '0 && w_in.packet_src <= w_n) begin
                                    n_flag[w_src_idx] = 1'b1;
                                    w_req_we   = 1'b1;
                                    w_req_addr = w_src_idx;
                                end else begin
                                    n_out.bad_slave = 1'b1;
                                end
                            end
                        end
                        ACT_GRANT: begin
                            n_out_vld = 1'b0;
                            n_idx     = '0;
                            n_found   = 1'b0;
                            n_state   = S_SCAN;
                        end
                        ACT_DATA: begin
                            if (w_in.packet_dst == r_own && r_lw != '0 && r_lw_dz) begin
                                n_ack[IDX_W'(r_lw - ADDR_W'(1))] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                n_idx    = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(MAX_SLAVES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    n_state   = S_IDLE;
                    if (r_found) begin
                        w_tot_we           = 1'b1;
                        w_tot_addr         = r_best;
                        n_tot_vld[r_best]  = 1'b1;
                        n_flag[r_best]     = 1'b0;
                        n_lw               = ADDR_W'(r_best) + ADDR_W'(1);
                        n_lw_dz            = (w_req_dest == '0);
                        n_out.granted      = 1'b1;
                        n_out.grant_slave  = ADDR_W'(r_best) + ADDR_W'(1);
                        n_out.grant_size   = w_req_bytes;
                    end else begin
                        n_lw    = '0;
                        n_lw_dz = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SLAVE_COUNT: begin
                    n_slave_cnt = i_cfg_wdata;
                    n_flag      = '0;
                    n_tot_vld   = '0;
                end
                CFG_OWN_ADDRESS: begin
                    n_own = i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan left early");

    a_grant_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.granted) |->
            (r_out.grant_slave != '0 && r_out.grant_size != '0))
        else $error("grant without slave or size");

    a_winner_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && w_out_free && r_found && !i_cfg_we) |=>
            !r_flag[$past(r_best)])
        else $error("winner flag not cleared");

    a_winner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lw <= ADDR_W'(MAX_SLAVES)))
        else $error("last winner out of range");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("item taken during grant");

endmodule
